// ===== rtl/core/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer pin table package
// Shared widths, codes, controller states and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bpt_pkg;

    // Defaults for the top-level parameters.
    localparam int FRAMES_DEF   = 16;
    localparam int PIN_BITS_DEF = 16;

    // Fixed field widths.
    localparam int KEY_W       = 32;
    localparam int SEL_W       = 4;
    localparam int STATUS_W    = 3;
    localparam int FRAME_OUT_W = 4;
    localparam int PIN_OUT_W   = 16;
    localparam int FREE_OUT_W  = 5;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Request kinds carried on s_tuser.
    typedef enum logic {
        CMD_PIN   = 1'b0,
        CMD_UNPIN = 1'b1
    } cmd_t;

    // Result codes carried on m_tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_HIT    = 3'd0,
        STATUS_NEW    = 3'd1,
        STATUS_FAIL   = 3'd2,
        STATUS_UNPIN  = 3'd3,
        STATUS_IGNORE = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UNPIN_RD,
        ST_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input beat and clear the scan state
        logic scan_run;  // walk the frame table looking for the key
        logic unpin_rd;  // read the frame selected for unpin
        logic update;    // write the table and load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;  // the scan found the key or checked every frame
        logic out_busy;  // the result register still holds an untaken beat
    } dp_stat_t;

endpackage

// ===== rtl/core/buffer_pin_table.sv =====
// Sequence: an unpin is accepted, reads its frame and then updates; a pin is
// accepted, scans until it finds the key or has checked every frame, then updates.
// Throughput: one request at a time, set by the one-frame-per-cycle table scan
// through the single read port of the frame memories.
// Reset: synchronous, active low; clears valid flags, sets the free count to
// FRAMES and empties the result register. Keys and counts need no clearing.
// ----------------------------------------------------------------------------
// Buffer pin table
// Buffer-pool pin and unpin manager: finds a frame holding a block key or
// gives the key to the first unpinned frame, and keeps per-frame pin counts.
// ----------------------------------------------------------------------------
module buffer_pin_table #(
    parameter int FRAMES   = bpt_pkg::FRAMES_DEF,
    parameter int PIN_BITS = bpt_pkg::PIN_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpt_pkg::S_TDATA_W-1:0]   s_tdata,   // block_key, frame_sel, zero pad
    input  logic                            s_tuser,   // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpt_pkg::M_TDATA_W-1:0]   m_tdata,   // frame_out, pin_count_out,
                                                       // free_frames, zero pad
    output logic [bpt_pkg::STATUS_W-1:0]    m_tuser    // status
);

    bpt_pkg::ctrl_cmd_t cmd;
    bpt_pkg::dp_stat_t  stat;

    // Request sequencer.
    bpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Frame table and result datapath.
    bpt_datapath #(
        .FRAMES   (FRAMES),
        .PIN_BITS (PIN_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/bpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buffer pin table controller
// Sequences one request at a time: accept, table scan or frame read,
// then the table update and result load.
// ----------------------------------------------------------------------------
module bpt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_cmd,
    input  bpt_pkg::dp_stat_t    stat,
    output bpt_pkg::ctrl_cmd_t   cmd
);

    bpt_pkg::state_t state_reg;
    bpt_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            bpt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (bpt_pkg::cmd_t'(s_cmd) == bpt_pkg::CMD_UNPIN) begin
                        state_next = bpt_pkg::ST_UNPIN_RD;
                    end else begin
                        state_next = bpt_pkg::ST_SCAN;
                    end
                end
            end
            bpt_pkg::ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_end) begin
                    state_next = bpt_pkg::ST_UPDATE;
                end
            end
            bpt_pkg::ST_UNPIN_RD: begin
                cmd.unpin_rd = 1'b1;
                state_next   = bpt_pkg::ST_UPDATE;
            end
            bpt_pkg::ST_UPDATE: begin
                // Wait until the result register can take the new beat.
                if (!stat.out_busy) begin
                    cmd.update = 1'b1;
                    state_next = bpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/bpt_datapath.sv =====
// ----------------------------------------------------------------------------
// Buffer pin table datapath
// Frame table memories, valid flags, scan counter, first-hit and first-free
// tracking, free-frame counter and the result register.
// ----------------------------------------------------------------------------
module bpt_datapath #(
    parameter int FRAMES   = bpt_pkg::FRAMES_DEF,
    parameter int PIN_BITS = bpt_pkg::PIN_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bpt_pkg::ctrl_cmd_t              cmd,
    output bpt_pkg::dp_stat_t               stat,
    input  logic                            s_tuser,
    input  logic [bpt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [bpt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [bpt_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNTW = $clog2(FRAMES + 1);
    localparam logic [CNTW-1:0]     FRAMES_C = CNTW'(FRAMES);
    localparam logic [PIN_BITS-1:0] PIN_MAX  = {PIN_BITS{1'b1}};
    localparam logic [PIN_BITS-1:0] PIN_ONE  = PIN_BITS'(1);

    // Frame table storage.
    logic [bpt_pkg::KEY_W-1:0] key_mem [FRAMES];
    logic [PIN_BITS-1:0]       cnt_mem [FRAMES];
    logic [FRAMES-1:0]         valid_reg;

    // Captured request.
    logic                        op_reg;
    logic [bpt_pkg::KEY_W-1:0]   key_reg;
    logic [bpt_pkg::SEL_W-1:0]   sel_reg;

    // Scan and read state.
    logic [CNTW-1:0]             idx_reg;
    logic                        rd_live_reg;
    logic                        rd_vbit_reg;
    logic [IDXW-1:0]             rd_idx_reg;
    logic [bpt_pkg::KEY_W-1:0]   rd_key_reg;
    logic [PIN_BITS-1:0]         rd_cnt_reg;
    logic                        hit_found_reg;
    logic                        free_found_reg;
    logic [IDXW-1:0]             free_idx_reg;
    logic [CNTW-1:0]             free_cnt_reg;
    logic [CNTW-1:0]             free_cnt_next;

    // Result register.
    logic                            m_tvalid_reg;
    logic [bpt_pkg::STATUS_W-1:0]    status_reg;
    logic [bpt_pkg::FRAME_OUT_W-1:0] frame_out_reg;
    logic [bpt_pkg::PIN_OUT_W-1:0]   pin_out_reg;
    logic [bpt_pkg::FREE_OUT_W-1:0]  free_out_reg;

    // Scan and update signals.
    logic [31:0]                 sel_wide;
    logic                        sel_ok;
    logic [IDXW-1:0]             sel_addr;
    logic                        issue;
    logic                        rd_en;
    logic [IDXW-1:0]             rd_addr;
    logic                        eval;
    logic [PIN_BITS-1:0]         cnt_eff;
    logic                        hit_now;
    logic                        free_now;
    logic                        cnt_we;
    logic                        key_we;
    logic [IDXW-1:0]             wr_addr;
    logic [PIN_BITS-1:0]         wr_cnt;
    bpt_pkg::status_t            status_new;
    logic [IDXW-1:0]             frame_new;
    logic [31:0]                 frame_wide;
    logic [31:0]                 pin_wide;
    logic [31:0]                 free_wide;

    // Frame selected for unpin, checked against the table size.
    assign sel_wide = 32'(sel_reg);
    assign sel_ok   = sel_wide < 32'(FRAMES);
    assign sel_addr = sel_wide[IDXW-1:0];

    // A frame's count is zero until its frame has been made valid.
    assign cnt_eff  = rd_vbit_reg ? rd_cnt_reg : '0;
    assign eval     = cmd.scan_run && rd_live_reg && !hit_found_reg;
    assign hit_now  = eval && rd_vbit_reg && (rd_key_reg == key_reg);
    assign free_now = eval && (cnt_eff == '0);

    // One table read per cycle: the scan address or the unpin frame.
    assign issue   = cmd.scan_run && !hit_found_reg && !hit_now && (idx_reg < FRAMES_C);
    assign rd_addr = issue ? idx_reg[IDXW-1:0] : sel_addr;
    assign rd_en   = issue || (cmd.unpin_rd && sel_ok);

    assign stat.scan_end = hit_found_reg || ((idx_reg == FRAMES_C) && !rd_live_reg);
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    // Table update and result selection.
    always_comb begin
        cnt_we        = 1'b0;
        key_we        = 1'b0;
        wr_addr       = rd_idx_reg;
        wr_cnt        = rd_cnt_reg;
        free_cnt_next = free_cnt_reg;
        status_new    = bpt_pkg::STATUS_FAIL;
        frame_new     = '0;
        if (bpt_pkg::cmd_t'(op_reg) == bpt_pkg::CMD_PIN) begin
            if (hit_found_reg) begin
                status_new = bpt_pkg::STATUS_HIT;
                frame_new  = rd_idx_reg;
                cnt_we     = cmd.update;
                if (rd_cnt_reg != PIN_MAX) begin
                    wr_cnt = rd_cnt_reg + PIN_ONE;
                end
                if (rd_cnt_reg == '0) begin
                    free_cnt_next = free_cnt_reg - CNTW'(1);
                end
            end else if (free_found_reg) begin
                status_new    = bpt_pkg::STATUS_NEW;
                frame_new     = free_idx_reg;
                wr_addr       = free_idx_reg;
                wr_cnt        = PIN_ONE;
                cnt_we        = cmd.update;
                key_we        = cmd.update;
                free_cnt_next = free_cnt_reg - CNTW'(1);
            end else begin
                wr_cnt = '0;
            end
        end else begin
            if (cnt_eff != '0) begin
                status_new = bpt_pkg::STATUS_UNPIN;
                cnt_we     = cmd.update;
                wr_cnt     = rd_cnt_reg - PIN_ONE;
                if (rd_cnt_reg == PIN_ONE) begin
                    free_cnt_next = free_cnt_reg + CNTW'(1);
                end
            end else begin
                status_new = bpt_pkg::STATUS_IGNORE;
                wr_cnt     = '0;
            end
        end
    end

    assign frame_wide = 32'(frame_new);
    assign pin_wide   = 32'(wr_cnt);
    assign free_wide  = 32'(free_cnt_next);

    // Table memories with registered reads.
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= key_reg;
        end
        if (cnt_we) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
            rd_idx_reg <= rd_addr;
        end
    end

    // Captured request fields.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata[bpt_pkg::KEY_W-1:0];
            sel_reg <= s_tdata[bpt_pkg::KEY_W +: bpt_pkg::SEL_W];
        end
    end

    // First free frame seen during the scan.
    always_ff @(posedge aclk) begin
        if (free_now && !free_found_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // Scan control, valid flags and free-frame counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            rd_live_reg    <= 1'b0;
            rd_vbit_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            free_cnt_reg   <= FRAMES_C;
        end else begin
            rd_live_reg <= rd_en;
            // The valid bit of the frame read stays put while the update waits.
            if (rd_en || cmd.unpin_rd) begin
                rd_vbit_reg <= rd_en && valid_reg[rd_addr];
            end
            if (cmd.load) begin
                idx_reg        <= '0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (issue) begin
                    idx_reg <= idx_reg + CNTW'(1);
                end
                if (hit_now) begin
                    hit_found_reg <= 1'b1;
                end
                if (free_now) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (key_we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.update) begin
                free_cnt_reg <= free_cnt_next;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            status_reg   <= status_new;
            free_out_reg <= free_wide[bpt_pkg::FREE_OUT_W-1:0];
            if (status_new == bpt_pkg::STATUS_UNPIN || status_new == bpt_pkg::STATUS_IGNORE) begin
                frame_out_reg <= sel_reg;
            end else begin
                frame_out_reg <= frame_wide[bpt_pkg::FRAME_OUT_W-1:0];
            end
            pin_out_reg <= pin_wide[bpt_pkg::PIN_OUT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, free_out_reg, pin_out_reg, frame_out_reg};

endmodule

// ===== rtl/core/bpt_checker.sv =====
// ----------------------------------------------------------------------------
// Buffer pin table checker
// Port-level checks on request sequencing and on result consistency.
// ----------------------------------------------------------------------------
module bpt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [bpt_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bpt_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [bpt_pkg::STATUS_W-1:0]    m_tuser
);

    // A request is in work after its beat, so the next beat is not taken at once.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("bpt: input taken in the cycle after an accepted beat");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("bpt: result beat changed while stalled");

    // A failed pin means every frame is pinned and reports frame, pin count and free count zero.
    a_fail_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == bpt_pkg::STATUS_FAIL) |-> (m_tdata[24:0] == 25'd0))
        else $error("bpt: failed pin with nonzero fields");

    // A frame newly given a key carries exactly one pin.
    a_new_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == bpt_pkg::STATUS_NEW) |-> (m_tdata[19:4] == 16'd1))
        else $error("bpt: new frame pin count is not one");

    // An ignored unpin reports a zero count.
    a_ignore_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == bpt_pkg::STATUS_IGNORE) |-> (m_tdata[19:4] == 16'd0))
        else $error("bpt: ignored unpin with nonzero count");

endmodule

bind buffer_pin_table bpt_checker u_bpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
